// ===== design/dtcs_pkg.sv =====
package dtcs_pkg;

  // configuration register indexes, byte address is 4 times the index
  localparam int unsigned CfgAddrW = 5;
  localparam logic [2:0] REG_STRAIGHT_STEP_LIMIT = 3'd0;
  localparam logic [2:0] REG_WAIT_TIME_MS        = 3'd1;
  localparam logic [2:0] REG_TURN_ANGLE_LIMIT    = 3'd2;
  localparam logic [2:0] REG_STRAIGHT_SPEED      = 3'd3;
  localparam logic [2:0] REG_TURN_SPEED          = 3'd4;

  // reset values of the configuration registers
  localparam logic [31:0] RST_STRAIGHT_STEP_LIMIT = 32'd1000;
  localparam logic [31:0] RST_WAIT_TIME_MS        = 32'd1000;
  localparam logic [15:0] RST_TURN_ANGLE_LIMIT    = 16'd16384;
  localparam logic signed [15:0] RST_STRAIGHT_SPEED = 16'sd1000;
  localparam logic signed [15:0] RST_TURN_SPEED     = 16'sd500;

  // stream payload widths
  localparam int unsigned InDataW  = 112;
  localparam int unsigned OutDataW = 32;

  // sequencer modes, one-hot
  typedef enum logic [2:0] {
    MODE_STRAIGHT = 3'b001,
    MODE_WAIT     = 3'b010,
    MODE_TURN     = 3'b100
  } mode_e;

  typedef struct packed {
    logic [31:0]        straight_step_limit;
    logic [31:0]        wait_time_ms;
    logic [15:0]        turn_angle_limit;
    logic signed [15:0] straight_speed;
    logic signed [15:0] turn_speed;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        left_count;
    logic [31:0]        right_count;
    logic [31:0]        now_ms;
    logic signed [15:0] yaw_angle;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } speed_t;

endpackage

// ===== design/drive_turn_calibration_sequencer_unit.sv =====
// channel   | direction | transaction payload
// ----------+-----------+-----------------------------------------------------
// s_axis    | in        | tdata: left_count, right_count, now_ms, yaw_angle
// m_axis    | out       | tdata: left_speed, right_speed
// apb       | in/out    | five configuration registers at byte address 4*index
//
// one transaction per cycle sustained while m_axis_tready stays high; an
// accepted sample moves from the input register into the result register
// once the result register is empty or its result is being taken
// the sequencer state updates when a sample moves into the result register
// a stalled result keeps its register; the input register still takes one
// more sample, then s_axis_tready drops until the result is taken
// reset is asynchronous, active low, and clears all control state
module drive_turn_calibration_sequencer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // stream input
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // left_count, right_count, now_ms, yaw_angle
  input  logic [dtcs_pkg::InDataW-1:0]       s_axis_tdata,
  // stream output
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // left_speed, right_speed
  output logic [dtcs_pkg::OutDataW-1:0]      m_axis_tdata,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dtcs_pkg::CfgAddrW-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import dtcs_pkg::*;

  cfg_t    cfg;
  logic    in_valid_q, in_valid_d;
  sample_t in_q;
  logic    out_valid_q, out_valid_d;
  speed_t  out_q;
  speed_t  speed;
  logic    advance;
  logic    in_take;

  dtcs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake between input register and result register
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;
  assign in_valid_d    = in_take | (in_valid_q & ~advance);
  assign out_valid_d   = advance | (out_valid_q & ~m_axis_tready);

  dtcs_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .sample_i (in_q),
    .speed_o  (speed)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.left_count  <= s_axis_tdata[31:0];
      in_q.right_count <= s_axis_tdata[63:32];
      in_q.now_ms      <= s_axis_tdata[95:64];
      in_q.yaw_angle   <= s_axis_tdata[111:96];
    end
    if (advance) begin
      out_q <= speed;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.right_speed, out_q.left_speed};

  // a waiting sample moves on whenever the result register is free
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q |-> advance)
    else $error("sample held while result register empty");

  // a taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && m_axis_tready && !in_valid_q |=> !out_valid_q)
    else $error("result repeated after being taken");

  // a stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

// ===== design/dtcs_cfg_regs.sv =====
module dtcs_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dtcs_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output dtcs_pkg::cfg_t                 cfg_o
);
  import dtcs_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[CfgAddrW-1:2];
  assign cfg_o   = cfg_q;

  // register writes, values masked to the register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.straight_step_limit <= RST_STRAIGHT_STEP_LIMIT;
      cfg_q.wait_time_ms        <= RST_WAIT_TIME_MS;
      cfg_q.turn_angle_limit    <= RST_TURN_ANGLE_LIMIT;
      cfg_q.straight_speed      <= RST_STRAIGHT_SPEED;
      cfg_q.turn_speed          <= RST_TURN_SPEED;
    end else if (wr_en) begin
      case (reg_idx)
        REG_STRAIGHT_STEP_LIMIT: cfg_q.straight_step_limit <= pwdata;
        REG_WAIT_TIME_MS:        cfg_q.wait_time_ms        <= pwdata;
        REG_TURN_ANGLE_LIMIT:    cfg_q.turn_angle_limit    <= pwdata[15:0];
        REG_STRAIGHT_SPEED:      cfg_q.straight_speed      <= pwdata[15:0];
        REG_TURN_SPEED:          cfg_q.turn_speed          <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_STRAIGHT_STEP_LIMIT: prdata = cfg_q.straight_step_limit;
      REG_WAIT_TIME_MS:        prdata = cfg_q.wait_time_ms;
      REG_TURN_ANGLE_LIMIT:    prdata = {16'd0, cfg_q.turn_angle_limit};
      REG_STRAIGHT_SPEED:      prdata = {16'd0, cfg_q.straight_speed};
      REG_TURN_SPEED:          prdata = {16'd0, cfg_q.turn_speed};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/dtcs_step.sv =====
module dtcs_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dtcs_pkg::cfg_t   cfg_i,
  input  logic             step_i,
  input  dtcs_pkg::sample_t sample_i,
  output dtcs_pkg::speed_t speed_o
);
  import dtcs_pkg::*;

  logic        started_q, started_d;
  mode_e       mode_q, mode_d;
  logic [31:0] left_start_q, left_start_d;
  logic [31:0] right_start_q, right_start_d;
  logic [31:0] wait_start_q, wait_start_d;
  logic [15:0] yaw_start_q, yaw_start_d;

  logic [31:0]        left_base, right_base;
  logic [31:0]        count_sum;
  logic               straight_done;
  logic               wait_done;
  logic [15:0]        yaw_diff;
  logic [16:0]        yaw_mag;
  logic               turn_done;
  logic signed [15:0] neg_turn;
  speed_t             speed;

  // first transaction after reset starts the drive from its own counts
  assign left_base  = started_q ? left_start_q  : sample_i.left_count;
  assign right_base = started_q ? right_start_q : sample_i.right_count;

  // end conditions of each mode
  assign count_sum     = (sample_i.left_count - left_base) + (sample_i.right_count - right_base);
  assign straight_done = {1'b0, count_sum[31:1]} >= cfg_i.straight_step_limit;
  assign wait_done     = (sample_i.now_ms - wait_start_q) >= cfg_i.wait_time_ms;
  assign yaw_diff      = sample_i.yaw_angle - yaw_start_q;
  assign yaw_mag       = yaw_diff[15] ? (17'h10000 - {1'b0, yaw_diff}) : {1'b0, yaw_diff};
  assign turn_done     = yaw_mag >= {1'b0, cfg_i.turn_angle_limit};
  assign neg_turn      = 16'sd0 - cfg_i.turn_speed;

  // mode sequencing and speed selection
  always_comb begin
    mode_d        = mode_q;
    left_start_d  = left_base;
    right_start_d = right_base;
    wait_start_d  = wait_start_q;
    yaw_start_d   = yaw_start_q;
    speed         = '0;
    case (mode_q)
      MODE_STRAIGHT: begin
        if (straight_done) begin
          mode_d       = MODE_WAIT;
          wait_start_d = sample_i.now_ms;
        end else begin
          speed.left_speed  = cfg_i.straight_speed;
          speed.right_speed = cfg_i.straight_speed;
        end
      end
      MODE_WAIT: begin
        if (wait_done) begin
          mode_d            = MODE_TURN;
          yaw_start_d       = sample_i.yaw_angle;
          speed.left_speed  = cfg_i.turn_speed;
          speed.right_speed = neg_turn;
        end
      end
      MODE_TURN: begin
        if (turn_done) begin
          mode_d            = MODE_STRAIGHT;
          left_start_d      = sample_i.left_count;
          right_start_d     = sample_i.right_count;
          speed.left_speed  = cfg_i.straight_speed;
          speed.right_speed = cfg_i.straight_speed;
        end else begin
          speed.left_speed  = cfg_i.turn_speed;
          speed.right_speed = neg_turn;
        end
      end
      default: ;
    endcase
  end

  assign started_d = 1'b1;
  assign speed_o   = speed;

  // sequencer state, updated once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q     <= 1'b0;
      mode_q        <= MODE_STRAIGHT;
      left_start_q  <= '0;
      right_start_q <= '0;
      wait_start_q  <= '0;
      yaw_start_q   <= '0;
    end else if (step_i) begin
      started_q     <= started_d;
      mode_q        <= mode_d;
      left_start_q  <= left_start_d;
      right_start_q <= right_start_d;
      wait_start_q  <= wait_start_d;
      yaw_start_q   <= yaw_start_d;
    end
  end

  // no mode change before the first transaction
  a_idle_straight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> mode_q == MODE_STRAIGHT)
    else $error("mode left straight drive before first transaction");

  // an expired wait always moves on to the turn
  a_wait_to_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && mode_q == MODE_WAIT && wait_done |=> mode_q == MODE_TURN)
    else $error("wait expired without entering turn");

  // standing still while the wait has not expired
  a_wait_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_WAIT && !wait_done |-> speed_o == '0)
    else $error("nonzero speed during wait");

  // the straight drive never ends on the first transaction unless the limit is zero
  a_first_straight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !started_q && cfg_i.straight_step_limit != 32'd0 |-> !straight_done)
    else $error("straight drive ended on its start sample");

endmodule
